FILE: design/dlcs_pkg.sv
package dlcs_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int MAX_EDGES_DEF = 4096;
	localparam int FW = 11;

	typedef enum logic [4:0] {
		S_IDLE, S_CLR,
		S_CNT_A, S_CNT_B, S_CNT_C,
		S_PFX_A, S_PFX_B,
		S_SCT_A, S_SCT_B, S_SCT_C,
		S_SEED_A, S_SEED_B,
		S_PROC_A, S_PROC_B, S_PROC_C, S_PROC_D, S_PROC_E, S_PROC_F, S_PROC_G,
		S_FIN
	} state_t;

	typedef enum logic [4:0] {
		OP_IDLE, OP_CLR,
		OP_CNT_A, OP_CNT_B, OP_CNT_C,
		OP_PFX_A, OP_PFX_B,
		OP_SCT_A, OP_SCT_B, OP_SCT_C,
		OP_SEED_A, OP_SEED_B,
		OP_PROC_A, OP_PROC_B, OP_PROC_C, OP_PROC_D, OP_PROC_E, OP_PROC_F, OP_PROC_G,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic edges_done;
		logic nodes_done;
		logic edge_bad;
		logic q_empty;
		logic k_done;
	} status_t;

endpackage

FILE: design/dlcs_ctrl.sv
module dlcs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              last_item,
	input  dlcs_pkg::status_t st,
	output dlcs_pkg::cmd_t    cmd,
	output logic              busy
);

	dlcs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlcs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = dlcs_pkg::OP_IDLE;
		cmd.load = 1'b0;
		busy     = 1'b1;
		case (state_q)
			dlcs_pkg::S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
				if (start && last_item) state_d = dlcs_pkg::S_CLR;
			end
			dlcs_pkg::S_CLR: begin
				cmd.op = dlcs_pkg::OP_CLR;
				if (st.clr_last) state_d = dlcs_pkg::S_CNT_A;
			end
			dlcs_pkg::S_CNT_A: begin
				cmd.op  = dlcs_pkg::OP_CNT_A;
				state_d = st.edges_done ? dlcs_pkg::S_PFX_A : dlcs_pkg::S_CNT_B;
			end
			dlcs_pkg::S_CNT_B: begin
				cmd.op  = dlcs_pkg::OP_CNT_B;
				state_d = st.edge_bad ? dlcs_pkg::S_FIN : dlcs_pkg::S_CNT_C;
			end
			dlcs_pkg::S_CNT_C: begin
				cmd.op  = dlcs_pkg::OP_CNT_C;
				state_d = dlcs_pkg::S_CNT_A;
			end
			dlcs_pkg::S_PFX_A: begin
				cmd.op  = dlcs_pkg::OP_PFX_A;
				state_d = st.nodes_done ? dlcs_pkg::S_SCT_A : dlcs_pkg::S_PFX_B;
			end
			dlcs_pkg::S_PFX_B: begin
				cmd.op  = dlcs_pkg::OP_PFX_B;
				state_d = dlcs_pkg::S_PFX_A;
			end
			dlcs_pkg::S_SCT_A: begin
				cmd.op  = dlcs_pkg::OP_SCT_A;
				state_d = st.edges_done ? dlcs_pkg::S_SEED_A : dlcs_pkg::S_SCT_B;
			end
			dlcs_pkg::S_SCT_B: begin
				cmd.op  = dlcs_pkg::OP_SCT_B;
				state_d = dlcs_pkg::S_SCT_C;
			end
			dlcs_pkg::S_SCT_C: begin
				cmd.op  = dlcs_pkg::OP_SCT_C;
				state_d = dlcs_pkg::S_SCT_A;
			end
			dlcs_pkg::S_SEED_A: begin
				cmd.op  = dlcs_pkg::OP_SEED_A;
				state_d = st.nodes_done ? dlcs_pkg::S_PROC_A : dlcs_pkg::S_SEED_B;
			end
			dlcs_pkg::S_SEED_B: begin
				cmd.op  = dlcs_pkg::OP_SEED_B;
				state_d = dlcs_pkg::S_SEED_A;
			end
			dlcs_pkg::S_PROC_A: begin
				cmd.op  = dlcs_pkg::OP_PROC_A;
				state_d = st.q_empty ? dlcs_pkg::S_FIN : dlcs_pkg::S_PROC_B;
			end
			dlcs_pkg::S_PROC_B: begin
				cmd.op  = dlcs_pkg::OP_PROC_B;
				state_d = dlcs_pkg::S_PROC_C;
			end
			dlcs_pkg::S_PROC_C: begin
				cmd.op  = dlcs_pkg::OP_PROC_C;
				state_d = dlcs_pkg::S_PROC_D;
			end
			dlcs_pkg::S_PROC_D: begin
				cmd.op  = dlcs_pkg::OP_PROC_D;
				state_d = dlcs_pkg::S_PROC_E;
			end
			dlcs_pkg::S_PROC_E: begin
				cmd.op  = dlcs_pkg::OP_PROC_E;
				state_d = st.k_done ? dlcs_pkg::S_PROC_A : dlcs_pkg::S_PROC_F;
			end
			dlcs_pkg::S_PROC_F: begin
				cmd.op  = dlcs_pkg::OP_PROC_F;
				state_d = dlcs_pkg::S_PROC_G;
			end
			dlcs_pkg::S_PROC_G: begin
				cmd.op  = dlcs_pkg::OP_PROC_G;
				state_d = dlcs_pkg::S_PROC_E;
			end
			dlcs_pkg::S_FIN: begin
				cmd.op  = dlcs_pkg::OP_FIN;
				state_d = dlcs_pkg::S_IDLE;
			end
			default: begin
				state_d = dlcs_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: design/dlcs_dp.sv
module dlcs_dp #(
	parameter int MAX_NODES = dlcs_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = dlcs_pkg::MAX_EDGES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dlcs_pkg::cmd_t          cmd,
	output dlcs_pkg::status_t       st,
	input  logic                    carries_edge,
	input  logic [dlcs_pkg::FW-1:0] from_node,
	input  logic [dlcs_pkg::FW-1:0] to_node,
	input  logic                    cfg_we,
	input  logic [dlcs_pkg::FW-1:0] cfg_data,
	output logic                    done,
	output logic [dlcs_pkg::FW-1:0] source_count,
	output logic [dlcs_pkg::FW-1:0] longest_chain,
	output logic                    error_flag
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int NCW = $clog2(MAX_NODES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW  = $clog2(MAX_EDGES + 1);
	localparam int IW  = (CW > NCW) ? CW : NCW;

	// control state
	logic [dlcs_pkg::FW-1:0] node_count_q;
	logic [CW-1:0]           cnt_q;
	logic                    err_seen_q;
	logic                    done_q;

	// walk registers
	logic [IW-1:0]  idx_q;
	logic [CW-1:0]  sum_q, k_q, kend_q;
	logic [NCW-1:0] head_q, tail_q, src_q, longest_q, cu_q;
	logic [NW-1:0]  u_q, v_q;
	logic           walk_err_q;
	logic [dlcs_pkg::FW-1:0] src_out_q, long_out_q;
	logic           err_out_q;

	// memories
	logic [2*NW-1:0] edge_mem [MAX_EDGES];
	logic [NW-1:0]   adj_mem  [MAX_EDGES];
	logic [CW-1:0]   indeg_mem[MAX_NODES];
	logic [NCW-1:0]  chain_mem[MAX_NODES];
	logic [CW-1:0]   ocnt_mem [MAX_NODES];
	logic [CW-1:0]   fill_mem [MAX_NODES];
	logic [NW-1:0]   queue_mem[MAX_NODES];

	logic [2*NW-1:0] edge_rd;
	logic [NW-1:0]   adj_rd, q_rd;
	logic [CW-1:0]   indeg_rd, ocnt_rd, fill_rd;
	logic [NCW-1:0]  chain_rd;

	logic [NW-1:0]  indeg_ra, chain_ra, ocnt_ra;
	logic           indeg_we, chain_we, ocnt_we, fill_we, adj_we, queue_we;
	logic [NW-1:0]  indeg_wa, chain_wa, ocnt_wa, fill_wa, queue_wd;
	logic [CW-1:0]  indeg_wd, ocnt_wd, fill_wd;
	logic [NCW-1:0] chain_wd;

	logic [NCW-1:0] n_eff;
	logic [31:0]    nc;
	logic           load_bad, load_full, edge_we;
	logic [NW-1:0]  ef, et, idx_n;
	logic [NCW-1:0] next_chain;
	logic           u_last;

	assign nc    = 32'(node_count_q);
	assign n_eff = (nc == 32'd0) ? NCW'(1) :
		((nc > 32'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(nc));

	assign load_bad  = (from_node == '0) || (to_node == '0) ||
		(32'(from_node) > 32'(n_eff)) || (32'(to_node) > 32'(n_eff));
	assign load_full = 32'(cnt_q) >= 32'(MAX_EDGES);
	assign edge_we   = cmd.load && carries_edge && !load_bad && !load_full;

	assign ef         = edge_rd[2*NW-1:NW];
	assign et         = edge_rd[NW-1:0];
	assign idx_n      = idx_q[NW-1:0];
	assign next_chain = cu_q + NCW'(1);
	assign u_last     = (NCW'(u_q) + NCW'(1)) == n_eff;

	assign st.clr_last   = (idx_q + IW'(1)) == IW'(n_eff);
	assign st.edges_done = idx_q == IW'(cnt_q);
	assign st.nodes_done = idx_q == IW'(n_eff);
	assign st.edge_bad   = (NCW'(ef) >= n_eff) || (NCW'(et) >= n_eff);
	assign st.q_empty    = head_q == tail_q;
	assign st.k_done     = k_q == kend_q;

	// memory address and write selection
	always_comb begin
		indeg_ra = idx_n;
		chain_ra = q_rd;
		ocnt_ra  = idx_n;
		indeg_we = 1'b0;
		chain_we = 1'b0;
		ocnt_we  = 1'b0;
		fill_we  = 1'b0;
		adj_we   = 1'b0;
		queue_we = 1'b0;
		indeg_wa = idx_n;
		chain_wa = idx_n;
		ocnt_wa  = idx_n;
		fill_wa  = idx_n;
		queue_wd = idx_n;
		indeg_wd = '0;
		chain_wd = NCW'(1);
		ocnt_wd  = '0;
		fill_wd  = sum_q;
		case (cmd.op)
			dlcs_pkg::OP_CLR: begin
				indeg_we = 1'b1;
				chain_we = 1'b1;
				ocnt_we  = 1'b1;
			end
			dlcs_pkg::OP_CNT_B: begin
				indeg_ra = et;
				ocnt_ra  = ef;
			end
			dlcs_pkg::OP_CNT_C: begin
				indeg_we = 1'b1;
				indeg_wa = et;
				indeg_wd = indeg_rd + CW'(1);
				ocnt_we  = 1'b1;
				ocnt_wa  = ef;
				ocnt_wd  = ocnt_rd + CW'(1);
			end
			dlcs_pkg::OP_PFX_B: begin
				ocnt_we = 1'b1;
				ocnt_wd = sum_q;
				fill_we = 1'b1;
			end
			dlcs_pkg::OP_SCT_C: begin
				adj_we  = 1'b1;
				fill_we = 1'b1;
				fill_wa = ef;
				fill_wd = fill_rd + CW'(1);
			end
			dlcs_pkg::OP_SEED_B: begin
				queue_we = indeg_rd == '0;
			end
			dlcs_pkg::OP_PROC_B: begin
				chain_ra = q_rd;
				ocnt_ra  = q_rd;
			end
			dlcs_pkg::OP_PROC_C: begin
				ocnt_ra = u_q + NW'(1);
			end
			dlcs_pkg::OP_PROC_F: begin
				chain_ra = adj_rd;
				indeg_ra = adj_rd;
			end
			dlcs_pkg::OP_PROC_G: begin
				chain_we = 1'b1;
				chain_wa = v_q;
				chain_wd = (chain_rd > next_chain) ? chain_rd : next_chain;
				indeg_we = 1'b1;
				indeg_wa = v_q;
				indeg_wd = indeg_rd - CW'(1);
				queue_we = indeg_rd == CW'(1);
				queue_wd = v_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (edge_we) edge_mem[cnt_q[EAW-1:0]] <= {NW'(from_node - 11'd1), NW'(to_node - 11'd1)};
		edge_rd <= edge_mem[idx_q[EAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (adj_we) adj_mem[fill_rd[EAW-1:0]] <= et;
		adj_rd <= adj_mem[k_q[EAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (indeg_we) indeg_mem[indeg_wa] <= indeg_wd;
		indeg_rd <= indeg_mem[indeg_ra];
	end

	always_ff @(posedge clk) begin
		if (chain_we) chain_mem[chain_wa] <= chain_wd;
		chain_rd <= chain_mem[chain_ra];
	end

	always_ff @(posedge clk) begin
		if (ocnt_we) ocnt_mem[ocnt_wa] <= ocnt_wd;
		ocnt_rd <= ocnt_mem[ocnt_ra];
	end

	always_ff @(posedge clk) begin
		if (fill_we) fill_mem[fill_wa] <= fill_wd;
		fill_rd <= fill_mem[ef];
	end

	always_ff @(posedge clk) begin
		if (queue_we) queue_mem[tail_q[NW-1:0]] <= queue_wd;
		q_rd <= queue_mem[head_q[NW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= dlcs_pkg::FW'(1);
			cnt_q        <= '0;
			err_seen_q   <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.op == dlcs_pkg::OP_FIN;
			if (cfg_we) node_count_q <= cfg_data;
			if (cmd.load && carries_edge && (load_bad || load_full)) err_seen_q <= 1'b1;
			if (edge_we) cnt_q <= cnt_q + CW'(1);
			if (cmd.op == dlcs_pkg::OP_FIN) begin
				cnt_q      <= '0;
				err_seen_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			dlcs_pkg::OP_IDLE: begin
				idx_q      <= '0;
				sum_q      <= '0;
				head_q     <= '0;
				tail_q     <= '0;
				src_q      <= '0;
				longest_q  <= '0;
				walk_err_q <= 1'b0;
			end
			dlcs_pkg::OP_CLR: begin
				idx_q <= st.clr_last ? '0 : idx_q + IW'(1);
			end
			dlcs_pkg::OP_CNT_A, dlcs_pkg::OP_SCT_A: begin
				if (st.edges_done) idx_q <= '0;
			end
			dlcs_pkg::OP_CNT_B: begin
				if (st.edge_bad) walk_err_q <= 1'b1;
			end
			dlcs_pkg::OP_CNT_C, dlcs_pkg::OP_SCT_C: begin
				idx_q <= idx_q + IW'(1);
			end
			dlcs_pkg::OP_PFX_A, dlcs_pkg::OP_SEED_A: begin
				if (st.nodes_done) idx_q <= '0;
			end
			dlcs_pkg::OP_PFX_B: begin
				sum_q <= sum_q + ocnt_rd;
				idx_q <= idx_q + IW'(1);
			end
			dlcs_pkg::OP_SEED_B: begin
				if (indeg_rd == '0) begin
					tail_q <= tail_q + NCW'(1);
					src_q  <= src_q + NCW'(1);
				end
				idx_q <= idx_q + IW'(1);
			end
			dlcs_pkg::OP_PROC_B: begin
				u_q <= q_rd;
			end
			dlcs_pkg::OP_PROC_C: begin
				cu_q <= chain_rd;
				k_q  <= ocnt_rd;
				if (chain_rd > longest_q) longest_q <= chain_rd;
			end
			dlcs_pkg::OP_PROC_D: begin
				// end of the out-list is the next node's start, or the edge total
				kend_q <= u_last ? cnt_q : ocnt_rd;
				head_q <= head_q + NCW'(1);
			end
			dlcs_pkg::OP_PROC_F: begin
				v_q <= adj_rd;
			end
			dlcs_pkg::OP_PROC_G: begin
				if (indeg_rd == CW'(1)) tail_q <= tail_q + NCW'(1);
				k_q <= k_q + CW'(1);
			end
			dlcs_pkg::OP_FIN: begin
				err_out_q <= err_seen_q || walk_err_q || (tail_q != n_eff);
				if (err_seen_q || walk_err_q || (tail_q != n_eff)) begin
					src_out_q  <= '0;
					long_out_q <= '0;
				end else begin
					src_out_q  <= dlcs_pkg::FW'(src_q);
					long_out_q <= dlcs_pkg::FW'(longest_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign done          = done_q;
	assign source_count  = src_out_q;
	assign longest_chain = long_out_q;
	assign error_flag    = err_out_q;

endmodule

FILE: design/dag_longest_chain_and_sources.sv
// edge words are taken one per cycle while idle; busy stays low between them
// the word marked last starts the graph walk: clear, count degrees, prefix offsets, scatter edges,
// seed the source queue, then process the queue node by node
// the result shows on the done strobe for one cycle, in the same cycle that busy falls
// reset sets node count to one and clears the edge count and the load error bit; memories need no clear
module dag_longest_chain_and_sources #(
	parameter int MAX_NODES = dlcs_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = dlcs_pkg::MAX_EDGES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    carries_edge,
	input  logic [dlcs_pkg::FW-1:0] from_node,
	input  logic [dlcs_pkg::FW-1:0] to_node,
	input  logic                    last_item,
	output logic                    done,
	output logic [dlcs_pkg::FW-1:0] source_count,
	output logic [dlcs_pkg::FW-1:0] longest_chain,
	output logic                    error_flag,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [dlcs_pkg::FW-1:0] cfg_data
);

	dlcs_pkg::cmd_t    cmd;
	dlcs_pkg::status_t st;

	assign cfg_ready = !busy;

	dlcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_item (last_item),
		.st        (st),
		.cmd       (cmd),
		.busy      (busy)
	);

	dlcs_dp #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.carries_edge  (carries_edge),
		.from_node     (from_node),
		.to_node       (to_node),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.source_count  (source_count),
		.longest_chain (longest_chain),
		.error_flag    (error_flag)
	);

	a_last_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_item |=> busy)
		else $error("last word did not start the walk");

	a_walk_ends_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("walk ended without a result");

	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		done && error_flag |-> source_count == '0 && longest_chain == '0)
		else $error("error result carries counts");

endmodule

FILE: tb/sv/dag_longest_chain_and_sources_tb.sv
`timescale 1ns / 1ps

module dag_longest_chain_and_sources_tb;

	localparam int FW = dlcs_pkg::FW;
	localparam int NODE_LIMIT = 1024;
	localparam int EDGE_LIMIT = 4096;
	localparam int STALL_LIMIT = 200000;

	typedef struct {
		bit              has_edge;
		bit [FW-1:0]     src_node;
		bit [FW-1:0]     dst_node;
		bit              closes;
	} edge_word_t;

	typedef struct {
		bit [FW-1:0] sources;
		bit [FW-1:0] chain;
		bit          err;
	} graph_summary_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic          carries_edge;
	logic [FW-1:0] from_node;
	logic [FW-1:0] to_node;
	logic          last_item;
	logic          done;
	logic [FW-1:0] source_count;
	logic [FW-1:0] longest_chain;
	logic          error_flag;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [FW-1:0] cfg_data;

	edge_word_t     word_queue[$];
	graph_summary_t summary_queue[$];
	int             idle_pct;
	int             fail_count;
	int             stall_cycles;
	int             word_count;

	// predictor state
	bit [FW-1:0] pred_node_count;
	int          pred_src[$];
	int          pred_dst[$];
	bit          pred_err;
	int          succ[NODE_LIMIT][$];
	int          indeg[NODE_LIMIT];
	int          depth[NODE_LIMIT];
	int          topo[NODE_LIMIT];

	dag_longest_chain_and_sources DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.carries_edge(carries_edge), .from_node(from_node), .to_node(to_node),
		.last_item(last_item), .done(done), .source_count(source_count),
		.longest_chain(longest_chain), .error_flag(error_flag),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int clamp_nodes(bit [FW-1:0] v);
		if (v < 1) return 1;
		if (v > NODE_LIMIT) return NODE_LIMIT;
		return int'(v);
	endfunction

	// kahn ordering with per-node chain depth
	function automatic graph_summary_t walk_graph();
		graph_summary_t r;
		int n;
		bit err;
		int head;
		int tail;
		int sources;
		int longest;
		int u;
		int v;
		n = clamp_nodes(pred_node_count);
		err = pred_err;
		head = 0;
		tail = 0;
		sources = 0;
		longest = 0;
		foreach (pred_src[e])
			if (pred_src[e] >= n || pred_dst[e] >= n) err = 1;
		if (!err) begin
			for (int i = 0; i < n; i++) begin
				succ[i].delete();
				indeg[i] = 0;
				depth[i] = 1;
			end
			foreach (pred_src[e]) begin
				succ[pred_src[e]].insert(succ[pred_src[e]].size(), pred_dst[e]);
				indeg[pred_dst[e]]++;
			end
			for (int i = 0; i < n; i++)
				if (indeg[i] == 0) begin
					topo[tail++] = i;
					sources++;
				end
			while (head < tail) begin
				u = topo[head++];
				if (depth[u] > longest) longest = depth[u];
				foreach (succ[u][k]) begin
					v = succ[u][k];
					if (depth[u] + 1 > depth[v]) depth[v] = depth[u] + 1;
					indeg[v]--;
					if (indeg[v] == 0) topo[tail++] = v;
				end
			end
			if (tail < n) err = 1;
		end
		r.err = err;
		r.sources = err ? '0 : FW'(sources);
		r.chain = err ? '0 : FW'(longest);
		pred_src.delete();
		pred_dst.delete();
		pred_err = 0;
		return r;
	endfunction

	function automatic void predict_word(edge_word_t w);
		int n;
		n = clamp_nodes(pred_node_count);
		if (w.has_edge) begin
			if (w.src_node == 0 || w.dst_node == 0 || w.src_node > n || w.dst_node > n)
				pred_err = 1;
			else if (pred_src.size() >= EDGE_LIMIT)
				pred_err = 1;
			else begin
				pred_src.insert(pred_src.size(), int'(w.src_node) - 1);
				pred_dst.insert(pred_dst.size(), int'(w.dst_node) - 1);
			end
		end
		if (w.closes) summary_queue.insert(summary_queue.size(), walk_graph());
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			carries_edge <= 1'b0;
			from_node <= '0;
			to_node <= '0;
			last_item <= 1'b0;
		end else begin
			if (start && !busy) begin
				edge_word_t w;
				w.has_edge = carries_edge;
				w.src_node = from_node;
				w.dst_node = to_node;
				w.closes = last_item;
				predict_word(w);
			end
			if (!start || !busy) begin
				if (word_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
					edge_word_t nw;
					nw = word_queue.pop_front();
					start <= 1'b1;
					carries_edge <= nw.has_edge;
					from_node <= nw.src_node;
					to_node <= nw.dst_node;
					last_item <= nw.closes;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (summary_queue.size() == 0) begin
				$display("%0t: unexpected result src=%0d chain=%0d err=%0d", $time,
					source_count, longest_chain, error_flag);
				fail_count++;
			end else begin
				graph_summary_t exp_r;
				exp_r = summary_queue.pop_front();
				if (source_count !== exp_r.sources) begin
					$display("%0t: source_count expected %0d actual %0d", $time,
						exp_r.sources, source_count);
					fail_count++;
				end
				if (longest_chain !== exp_r.chain) begin
					$display("%0t: longest_chain expected %0d actual %0d", $time,
						exp_r.chain, longest_chain);
					fail_count++;
				end
				if (error_flag !== exp_r.err) begin
					$display("%0t: error_flag expected %0d actual %0d", $time,
						exp_r.err, error_flag);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any word moving
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic push_word(bit has_edge, bit [FW-1:0] s, bit [FW-1:0] d, bit closes);
		edge_word_t w;
		w.has_edge = has_edge;
		w.src_node = s;
		w.dst_node = d;
		w.closes = closes;
		word_queue.insert(word_queue.size(), w);
		word_count++;
	endtask

	task automatic wait_idle();
		while (word_queue.size() != 0 || start || summary_queue.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_node_count(bit [FW-1:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		pred_node_count = v;
		cfg_valid <= 1'b0;
		cfg_data <= FW'($urandom());
	endtask

	// random dag on a shuffled node order, with some cycles, bad nodes and empty words
	task automatic random_graph(int n, int edges);
		int perm[NODE_LIMIT];
		int a;
		int b;
		int tmp;
		int roll;
		for (int i = 0; i < n; i++) perm[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			a = $urandom_range(i);
			tmp = perm[i];
			perm[i] = perm[a];
			perm[a] = tmp;
		end
		for (int e = 0; e < edges; e++) begin
			roll = $urandom_range(99);
			if (roll < 3) begin
				push_word(0, FW'($urandom()), FW'($urandom()), 0);
			end else if (roll < 5 || n < 2) begin
				if ($urandom_range(1))
					push_word(1, FW'($urandom()), FW'($urandom_range(n)), 0);
				else
					push_word(1, FW'($urandom_range(n)), FW'($urandom()), 0);
			end else begin
				a = $urandom_range(n - 2);
				b = $urandom_range(n - 1, a + 1);
				if (roll < 8)
					push_word(1, FW'(perm[b] + 1), FW'(perm[a] + 1), 0);
				else
					push_word(1, FW'(perm[a] + 1), FW'(perm[b] + 1), 0);
			end
		end
		if ($urandom_range(1) || n < 2) begin
			push_word(0, FW'($urandom()), FW'($urandom()), 1);
		end else begin
			a = $urandom_range(n - 2);
			b = $urandom_range(n - 1, a + 1);
			push_word(1, FW'(perm[a] + 1), FW'(perm[b] + 1), 1);
		end
	endtask

	initial begin
		int sizes[8];
		int ph;
		int n;
		sizes = '{2, 3, 5, 8, 16, 30, 64, 1};
		fail_count = 0;
		stall_cycles = 0;
		word_count = 0;
		idle_pct = 0;
		pred_node_count = 1;
		pred_err = 0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset node count, empty graph
		push_word(0, 0, 0, 1);
		write_node_count(4);
		push_word(0, 2047, 2047, 0);
		push_word(0, 0, 0, 1);
		// chain of four with a duplicate edge
		push_word(1, 1, 2, 0);
		push_word(1, 2, 3, 0);
		push_word(1, 2, 3, 0);
		push_word(1, 3, 4, 1);
		// two-node cycle
		push_word(1, 1, 2, 0);
		push_word(1, 2, 1, 1);
		// self loop
		push_word(1, 3, 3, 1);
		// bad nodes
		push_word(1, 0, 2, 1);
		push_word(1, 1, 5, 1);
		push_word(1, 2047, 1, 1);
		push_word(1, 1, 1024, 1);
		// diamond
		push_word(1, 1, 2, 0);
		push_word(1, 1, 3, 0);
		push_word(1, 2, 4, 0);
		push_word(1, 3, 4, 1);
		write_node_count(0);
		push_word(0, 0, 0, 1);
		push_word(1, 1, 1, 1);
		// largest graphs: all sources, then the longest chain
		write_node_count(2047);
		push_word(0, 0, 0, 1);
		write_node_count(1024);
		for (int i = 1; i < NODE_LIMIT; i++) push_word(1, FW'(i), FW'(i + 1), 0);
		push_word(0, 0, 0, 1);
		idle_pct = 12;
		random_graph(NODE_LIMIT, 150);
		idle_pct = 0;

		ph = 0;
		while (word_count < 1750) begin
			n = sizes[ph % 8];
			write_node_count(FW'(n));
			case (ph % 3)
				0: idle_pct = 0;
				1: idle_pct = 57;
				default: idle_pct = 12;
			endcase
			repeat (6) random_graph(n, $urandom_range(2 * n + 2));
			ph++;
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
